FILE: design/dgrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgrc_pkg
// Shared types and constants of the grid ray caster: configuration record,
// controller command and status words, divider and rotator widths.
// ----------------------------------------------------------------------------
package dgrc_pkg;

  localparam int DVD_W      = 25;
  localparam int DVS_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DIST_W     = 17;
  localparam int COR_W      = 18;
  localparam int COR_ITERS  = 14;

  localparam logic [DIST_W-1:0]       DIST_SAT = '1;
  localparam logic signed [COR_W-1:0] COR_GAIN = 18'sd9949;
  localparam logic [DVD_W-1:0]        UNIT_NUM = 25'h100_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_RAY_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SPAN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd4;

  typedef struct packed {
    logic [6:0]  ray_count;
    logic [14:0] view_span;
    logic [16:0] max_distance;
    logic [6:0]  map_width;
    logic [6:0]  map_height;
  } cfg_t;

  typedef struct packed {
    logic clr;
    logic wr;
    logic load;
    logic ang_start;
    logic ang_done;
    logic cor_init;
    logic cor_step;
    logic dir;
    logic ux_start;
    logic ux_done;
    logic uy_start;
    logic uy_done;
    logic side_x;
    logic side_y;
    logic step;
    logic check;
    logic wall_x;
    logic wall_y;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic cor_last;
    logic run;
    logic hit_now;
    logic last_ray;
    logic out_free;
  } sts_t;

  function automatic logic signed [COR_W-1:0] atan_lut(input logic [3:0] idx);
    logic signed [COR_W-1:0] v;
    case (idx)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: design/dgrc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgrc_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dgrc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dgrc_pkg::DVD_W-1:0]  dividend_i,
  input  logic [dgrc_pkg::DVS_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [dgrc_pkg::DVD_W-1:0]  quot_o
);

  localparam int DVD_W = dgrc_pkg::DVD_W;
  localparam int DVS_W = dgrc_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   rem_d;
  logic             fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign rem_d = fits ? trial - {1'b0, dvs_q} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= rem_d[DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

FILE: design/dgrc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgrc_dp
// Datapath: map store, angle and direction unit, shared divider and
// multiplier, cell stepping registers, result register.
// ----------------------------------------------------------------------------
module dgrc_dp #(
  parameter int MAP_DIM   = 64,
  parameter int MAX_RAYS  = 64,
  parameter int CELL_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dgrc_pkg::cmd_t      cmd_i,
  output dgrc_pkg::sts_t      sts_o,
  input  dgrc_pkg::cfg_t      cfg_i,
  input  logic [5:0]          cell_x_i,
  input  logic [5:0]          cell_y_i,
  input  logic [7:0]          cell_value_i,
  input  logic [15:0]         pos_x_i,
  input  logic [15:0]         pos_y_i,
  input  logic [15:0]         heading_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                hit_o,
  output logic [16:0]         distance_o,
  output logic [15:0]         wall_px_o,
  output logic [15:0]         wall_py_o,
  output logic [16:0]         perp_distance_o,
  output logic                x_side_o,
  output logic [7:0]          wall_value_o,
  output logic [15:0]         ray_angle_o,
  output logic signed [15:0]  dir_x_o,
  output logic signed [15:0]  dir_y_o,
  output logic                last_o
);

  localparam int IDX_W  = $clog2(MAP_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int DIM_W  = $clog2(MAP_DIM + 1);
  localparam int DW     = dgrc_pkg::DIST_W;
  localparam int CW     = dgrc_pkg::COR_W;

  // map store
  logic [CELL_BITS-1:0] mem [DEPTH];
  logic [CELL_BITS-1:0] rdata_q;
  logic [ADDR_W-1:0]    clr_addr_q;
  logic                 clr_done_q;
  logic                 we;
  logic [ADDR_W-1:0]    wa;
  logic [CELL_BITS-1:0] wd;
  logic [ADDR_W-1:0]    ra;
  logic                 wr_ok;

  // cast and ray state
  logic [15:0]          pos_x_q, pos_y_q, start_q, ang_q;
  logic [6:0]           ray_q;
  logic [1:0]           quad_q;
  logic [3:0]           it_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [15:0]   dx_q, dy_q;
  logic [DW-1:0]        ux_q, uy_q, sx_q, sy_q, dist_q;
  logic [9:0]           cx_q, cy_q;
  logic                 xs_q, hit_q, inb_q;
  logic [7:0]           val_q;
  logic [15:0]          wpx_q, wpy_q;

  // result register
  logic                 ov_q;
  logic                 o_hit_q, o_xs_q, o_last_q;
  logic [DW-1:0]        o_dist_q;
  logic [15:0]          o_wpx_q, o_wpy_q, o_ang_q;
  logic [7:0]           o_val_q;
  logic signed [15:0]   o_dx_q, o_dy_q;

  logic [6:0]           n_lim;
  logic [DIM_W-1:0]     w_lim, h_lim;
  logic                 last_ray;
  logic                 out_free;

  always_comb begin
    if (cfg_i.ray_count == 7'd0) begin
      n_lim = 7'd1;
    end else if (32'(cfg_i.ray_count) > 32'(MAX_RAYS)) begin
      n_lim = 7'(MAX_RAYS);
    end else begin
      n_lim = cfg_i.ray_count;
    end
    w_lim = (32'(cfg_i.map_width) > 32'(MAP_DIM)) ? DIM_W'(MAP_DIM) : DIM_W'(cfg_i.map_width);
    h_lim = (32'(cfg_i.map_height) > 32'(MAP_DIM)) ? DIM_W'(MAP_DIM) : DIM_W'(cfg_i.map_height);
  end

  assign last_ray = (ray_q + 7'd1) == n_lim;
  assign out_free = !ov_q || !out_stall_i;

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  logic [10:0]        span_x, span_y;

  assign span_x = dx_q[15] ? {1'b0, pos_x_q[9:0]} : 11'd1024 - {1'b0, pos_x_q[9:0]};
  assign span_y = dy_q[15] ? {1'b0, pos_y_q[9:0]} : 11'd1024 - {1'b0, pos_y_q[9:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.ang_start) begin
      mul_a = {11'd0, ray_q};
      mul_b = {3'd0, cfg_i.view_span};
    end else if (cmd_i.side_x) begin
      mul_a = {7'd0, span_x};
      mul_b = {1'b0, ux_q};
    end else if (cmd_i.side_y) begin
      mul_a = {7'd0, span_y};
      mul_b = {1'b0, uy_q};
    end else if (cmd_i.wall_x) begin
      mul_a = {{2{dx_q[15]}}, dx_q};
      mul_b = {1'b0, dist_q};
    end else if (cmd_i.wall_y) begin
      mul_a = {{2{dy_q[15]}}, dy_q};
      mul_b = {1'b0, dist_q};
    end
  end

  assign prod = mul_a * mul_b;

  // shared divider
  logic                         div_start, div_done;
  logic [dgrc_pkg::DVD_W-1:0]   div_dvd, quot;
  logic [dgrc_pkg::DVS_W-1:0]   div_dvs;
  logic [15:0]                  abs_dx, abs_dy;
  logic [DW-1:0]                unit_q;
  logic                         unit_zero;

  assign abs_dx    = dx_q[15] ? 16'(-dx_q) : 16'(dx_q);
  assign abs_dy    = dy_q[15] ? 16'(-dy_q) : 16'(dy_q);
  assign div_start = cmd_i.ang_start || cmd_i.ux_start || cmd_i.uy_start;
  assign div_dvd   = cmd_i.ang_start ? prod[dgrc_pkg::DVD_W-1:0] : dgrc_pkg::UNIT_NUM;

  always_comb begin
    if (cmd_i.ang_start) begin
      div_dvs = {8'd0, n_lim};
    end else if (cmd_i.ux_start) begin
      div_dvs = abs_dx[14:0];
    end else begin
      div_dvs = abs_dy[14:0];
    end
  end

  dgrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign unit_zero = cmd_i.ux_done ? (abs_dx == 16'd0) : (abs_dy == 16'd0);
  assign unit_q    = (unit_zero || (|quot[dgrc_pkg::DVD_W-1:DW])) ? dgrc_pkg::DIST_SAT
                                                                  : quot[DW-1:0];

  // angle reduction and rotation step
  logic [15:0]          ang_bias, z_init;
  logic [1:0]           quad_n;
  logic signed [CW-1:0] x_sh, y_sh, atan_v;
  logic signed [15:0]   cx_cl, cy_cl;

  assign ang_bias = ang_q + 16'd8192;
  assign quad_n   = ang_bias[15:14];
  assign z_init   = ang_q - {quad_n, 14'd0};
  assign x_sh     = x_q >>> it_q;
  assign y_sh     = y_q >>> it_q;
  assign atan_v   = dgrc_pkg::atan_lut(it_q);

  always_comb begin
    if (x_q > 18'sd16384) begin
      cx_cl = 16'sd16384;
    end else if (x_q < -18'sd16384) begin
      cx_cl = -16'sd16384;
    end else begin
      cx_cl = x_q[15:0];
    end
    if (y_q > 18'sd16384) begin
      cy_cl = 16'sd16384;
    end else if (y_q < -18'sd16384) begin
      cy_cl = -16'sd16384;
    end else begin
      cy_cl = y_q[15:0];
    end
  end

  // side distances
  logic [DW-1:0] side_sat;
  assign side_sat = (|prod[35:27]) ? dgrc_pkg::DIST_SAT : prod[26:10];

  // cell step
  logic          take_x;
  logic [9:0]    cx_n, cy_n;
  logic [DW:0]   sx_sum, sy_sum;
  logic          inb_n;

  assign take_x = sx_q < sy_q;
  assign cx_n   = take_x ? cx_q + (dx_q[15] ? 10'h3FF : 10'd1) : cx_q;
  assign cy_n   = take_x ? cy_q : cy_q + (dy_q[15] ? 10'h3FF : 10'd1);
  assign sx_sum = {1'b0, sx_q} + {1'b0, ux_q};
  assign sy_sum = {1'b0, sy_q} + {1'b0, uy_q};
  assign inb_n  = !cx_n[9] && (32'(cx_n[8:0]) < 32'(w_lim))
               && !cy_n[9] && (32'(cy_n[8:0]) < 32'(h_lim));
  assign ra     = {cx_n[IDX_W-1:0], cy_n[IDX_W-1:0]};

  // wall point
  logic [35:0]        prod_sh;
  logic signed [36:0] wall_sum;
  logic [15:0]        wall_cl;

  assign prod_sh  = 36'(prod >>> 14);
  assign wall_sum = $signed({21'd0, (cmd_i.wall_x ? pos_x_q : pos_y_q)})
                  + $signed({prod_sh[35], prod_sh});

  always_comb begin
    if (wall_sum < 37'sd0) begin
      wall_cl = 16'd0;
    end else if (wall_sum > 37'sd65535) begin
      wall_cl = 16'hFFFF;
    end else begin
      wall_cl = wall_sum[15:0];
    end
  end

  // memory port
  assign wr_ok = cmd_i.wr && (32'(cell_x_i) < 32'(MAP_DIM)) && (32'(cell_y_i) < 32'(MAP_DIM));
  assign we    = cmd_i.clr || wr_ok;
  assign wa    = cmd_i.clr ? clr_addr_q : {IDX_W'(cell_x_i), IDX_W'(cell_y_i)};
  assign wd    = cmd_i.clr ? '0 : CELL_BITS'(cell_value_i);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_done_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          clr_done_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      start_q <= heading_i - {2'd0, cfg_i.view_span[14:1]};
      ray_q   <= '0;
    end
    if (cmd_i.ang_done) begin
      ang_q <= start_q + quot[15:0];
    end
    if (cmd_i.cor_init) begin
      quad_q <= quad_n;
      x_q    <= dgrc_pkg::COR_GAIN;
      y_q    <= '0;
      z_q    <= {{2{z_init[15]}}, z_init};
      it_q   <= '0;
    end
    if (cmd_i.cor_step) begin
      if (!z_q[CW-1]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_v;
      end
      it_q <= it_q + 4'd1;
    end
    if (cmd_i.dir) begin
      case (quad_q)
        2'd0: begin
          dx_q <= cx_cl;
          dy_q <= cy_cl;
        end
        2'd1: begin
          dx_q <= -cy_cl;
          dy_q <= cx_cl;
        end
        2'd2: begin
          dx_q <= -cx_cl;
          dy_q <= -cy_cl;
        end
        default: begin
          dx_q <= cy_cl;
          dy_q <= -cx_cl;
        end
      endcase
    end
    if (cmd_i.ux_done) begin
      ux_q <= unit_q;
    end
    if (cmd_i.uy_done) begin
      uy_q <= unit_q;
    end
    if (cmd_i.side_x) begin
      sx_q   <= side_sat;
      cx_q   <= {4'd0, pos_x_q[15:10]};
      cy_q   <= {4'd0, pos_y_q[15:10]};
      dist_q <= '0;
      hit_q  <= 1'b0;
      xs_q   <= 1'b0;
    end
    if (cmd_i.side_y) begin
      sy_q <= side_sat;
    end
    if (cmd_i.step) begin
      cx_q  <= cx_n;
      cy_q  <= cy_n;
      inb_q <= inb_n;
      xs_q  <= take_x;
      if (take_x) begin
        dist_q <= sx_q;
        sx_q   <= sx_sum[DW] ? dgrc_pkg::DIST_SAT : sx_sum[DW-1:0];
      end else begin
        dist_q <= sy_q;
        sy_q   <= sy_sum[DW] ? dgrc_pkg::DIST_SAT : sy_sum[DW-1:0];
      end
    end
    if (cmd_i.check) begin
      hit_q <= sts_o.hit_now;
      val_q <= 8'(rdata_q);
    end
    if (cmd_i.wall_x) begin
      wpx_q <= wall_cl;
    end
    if (cmd_i.wall_y) begin
      wpy_q <= wall_cl;
    end
    if (cmd_i.emit) begin
      o_hit_q  <= hit_q;
      o_dist_q <= hit_q ? dist_q : '0;
      o_wpx_q  <= hit_q ? wpx_q : '0;
      o_wpy_q  <= hit_q ? wpy_q : '0;
      o_xs_q   <= xs_q;
      o_val_q  <= hit_q ? val_q : '0;
      o_ang_q  <= ang_q;
      o_dx_q   <= dx_q;
      o_dy_q   <= dy_q;
      o_last_q <= last_ray;
      ray_q    <= ray_q + 7'd1;
    end
  end

  assign sts_o.clr_last = &clr_addr_q;
  assign sts_o.div_done = div_done;
  assign sts_o.cor_last = it_q == 4'(dgrc_pkg::COR_ITERS - 1);
  assign sts_o.run      = dist_q < cfg_i.max_distance;
  assign sts_o.hit_now  = inb_q && (rdata_q != '0);
  assign sts_o.last_ray = last_ray;
  assign sts_o.out_free = out_free;

  assign out_valid_o     = ov_q;
  assign hit_o           = o_hit_q;
  assign distance_o      = o_dist_q;
  assign wall_px_o       = o_wpx_q;
  assign wall_py_o       = o_wpy_q;
  assign perp_distance_o = o_dist_q;
  assign x_side_o        = o_xs_q;
  assign wall_value_o    = o_val_q;
  assign ray_angle_o     = o_ang_q;
  assign dir_x_o         = o_dx_q;
  assign dir_y_o         = o_dy_q;
  assign last_o          = o_last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded while output word still held");

  a_wall_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wall_x || cmd_i.wall_y) |-> hit_q)
    else $error("wall point computed without a hit");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (dist_q < cfg_i.max_distance))
    else $error("cell step past max distance");

  a_wr_after_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> clr_done_q)
    else $error("map write before clear pass finished");

endmodule
`default_nettype wire

FILE: design/dgrc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgrc_ctrl
// Sequencer: clear pass, item intake, per-ray setup, cell walk, result hand-off.
// ----------------------------------------------------------------------------
module dgrc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            func_i,
  output logic            in_stall_o,
  input  dgrc_pkg::sts_t  sts_i,
  output dgrc_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ANG, S_ANG_W, S_COR_INIT, S_COR, S_DIR,
    S_UX, S_UX_W, S_UY, S_UY_W, S_SIDE_X, S_SIDE_Y,
    S_STEP, S_CHECK, S_WALL_X, S_WALL_Y, S_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_ANG;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      S_ANG: begin
        cmd_o.ang_start = 1'b1;
        state_d         = S_ANG_W;
      end
      S_ANG_W: begin
        if (sts_i.div_done) begin
          cmd_o.ang_done = 1'b1;
          state_d        = S_COR_INIT;
        end
      end
      S_COR_INIT: begin
        cmd_o.cor_init = 1'b1;
        state_d        = S_COR;
      end
      S_COR: begin
        cmd_o.cor_step = 1'b1;
        if (sts_i.cor_last) begin
          state_d = S_DIR;
        end
      end
      S_DIR: begin
        cmd_o.dir = 1'b1;
        state_d   = S_UX;
      end
      S_UX: begin
        cmd_o.ux_start = 1'b1;
        state_d        = S_UX_W;
      end
      S_UX_W: begin
        if (sts_i.div_done) begin
          cmd_o.ux_done = 1'b1;
          state_d       = S_UY;
        end
      end
      S_UY: begin
        cmd_o.uy_start = 1'b1;
        state_d        = S_UY_W;
      end
      S_UY_W: begin
        if (sts_i.div_done) begin
          cmd_o.uy_done = 1'b1;
          state_d       = S_SIDE_X;
        end
      end
      S_SIDE_X: begin
        cmd_o.side_x = 1'b1;
        state_d      = S_SIDE_Y;
      end
      S_SIDE_Y: begin
        cmd_o.side_y = 1'b1;
        state_d      = S_STEP;
      end
      S_STEP: begin
        if (sts_i.run) begin
          cmd_o.step = 1'b1;
          state_d    = S_CHECK;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.hit_now ? S_WALL_X : S_STEP;
      end
      S_WALL_X: begin
        cmd_o.wall_x = 1'b1;
        state_d      = S_WALL_Y;
      end
      S_WALL_Y: begin
        cmd_o.wall_y = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last_ray ? S_IDLE : S_ANG;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/dda_grid_ray_caster.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_grid_ray_caster
// Grid map ray caster: map cell writes, then casts of evenly spread rays that
// walk the grid cell by cell and report the first wall struck.
// ----------------------------------------------------------------------------
// after reset a clear pass zeroes the map, one cell a cycle (4096 cells at
// MAP_DIM 64), while no word is taken; config writes are taken throughout
// a map write word leaves the controller idle, ready for the next word
// each ray runs a setup of three divides on the shared divider and 14
// rotation steps, then walks the grid cell by cell, a step and a check per cell
// a cast runs its rays in turn; the next word is taken after the last ray
// ----------------------------------------------------------------------------
module dda_grid_ray_caster #(
  parameter int MAP_DIM   = 64,
  parameter int MAX_RAYS  = 64,
  parameter int CELL_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dgrc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [dgrc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   func_i,
  input  logic [5:0]                             cell_x_i,
  input  logic [5:0]                             cell_y_i,
  input  logic [7:0]                             cell_value_i,
  input  logic [15:0]                            pos_x_i,
  input  logic [15:0]                            pos_y_i,
  input  logic [15:0]                            heading_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   hit_o,
  output logic [16:0]                            distance_o,
  output logic [15:0]                            wall_px_o,
  output logic [15:0]                            wall_py_o,
  output logic [16:0]                            perp_distance_o,
  output logic                                   x_side_o,
  output logic [7:0]                             wall_value_o,
  output logic [15:0]                            ray_angle_o,
  output logic signed [15:0]                     dir_x_o,
  output logic signed [15:0]                     dir_y_o,
  output logic                                   last_o
);

  dgrc_pkg::cfg_t cfg_q;
  dgrc_pkg::cmd_t cmd;
  dgrc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ray_count    <= 7'd64;
      cfg_q.view_span    <= 15'd10923;
      cfg_q.max_distance <= 17'd20480;
      cfg_q.map_width    <= 7'd64;
      cfg_q.map_height   <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dgrc_pkg::CFG_RAY_COUNT:  cfg_q.ray_count    <= cfg_data_i[6:0];
        dgrc_pkg::CFG_VIEW_SPAN:  cfg_q.view_span    <= cfg_data_i[14:0];
        dgrc_pkg::CFG_MAX_DIST:   cfg_q.max_distance <= cfg_data_i;
        dgrc_pkg::CFG_MAP_WIDTH:  cfg_q.map_width    <= cfg_data_i[6:0];
        dgrc_pkg::CFG_MAP_HEIGHT: cfg_q.map_height   <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  dgrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dgrc_dp #(
    .MAP_DIM   (MAP_DIM),
    .MAX_RAYS  (MAX_RAYS),
    .CELL_BITS (CELL_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_i           (cfg_q),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_value_i    (cell_value_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .heading_i       (heading_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .hit_o           (hit_o),
    .distance_o      (distance_o),
    .wall_px_o       (wall_px_o),
    .wall_py_o       (wall_py_o),
    .perp_distance_o (perp_distance_o),
    .x_side_o        (x_side_o),
    .wall_value_o    (wall_value_o),
    .ray_angle_o     (ray_angle_o),
    .dir_x_o         (dir_x_o),
    .dir_y_o         (dir_y_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire
